@@ hw/rtl/cms_pkg.sv @@
// Shared types and constants for the cycle measurement statistics core.
`timescale 1ns / 1ps

package cms_pkg;

    localparam int unsigned CapWidth   = 17;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned StepWidth  = 5;

    // Register index inside the APB window (word aligned, bit 2 of paddr).
    localparam logic REG_OVERHEAD = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Result error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERHEAD = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] stop_time;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [31:0] duration;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] average;
        logic [31:0] outlier_count;
        logic [31:0] sample_count;
        logic        jitter;
        logic [1:0]  error_code;
    } t_out_item;

    typedef struct packed {
        logic [31:0] overhead;
        logic [16:0] capacity;
    } t_cfg;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
        logic        cin;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        cout;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_OVH,
        S_CAP,
        S_MIN,
        S_MAX,
        S_AVG,
        S_OUT,
        S_SUM_LO,
        S_SUM_HI,
        S_CNT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/cms_cfg_regs.sv @@
// APB configuration registers: static overhead and series capacity.
`timescale 1ns / 1ps

module cms_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cms_pkg::AddrWidth-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output cms_pkg::t_cfg                      o_cfg
);

    logic [31:0] r_overhead;
    logic [16:0] r_capacity;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overhead <= '0;
            r_capacity <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                cms_pkg::REG_OVERHEAD: r_overhead <= pwdata;
                cms_pkg::REG_CAPACITY: r_capacity <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cms_pkg::REG_OVERHEAD: prdata = r_overhead;
            cms_pkg::REG_CAPACITY: prdata = {15'd0, r_capacity};
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.overhead = r_overhead;
    assign o_cfg.capacity = r_capacity;

endmodule

@@ hw/rtl/cms_alu.sv @@
// Shared 32-bit adder/subtractor with carry in and carry out.
`timescale 1ns / 1ps

module cms_alu (
    input  cms_pkg::t_alu_req i_req,
    output cms_pkg::t_alu_rsp o_rsp
);

    logic [31:0] b_eff;
    logic        c_eff;
    logic [32:0] total;

    always_comb begin
        // Subtraction is a + ~b + 1; carry out high means no borrow (a >= b).
        b_eff = (i_req.op == cms_pkg::ALU_SUB) ? ~i_req.b : i_req.b;
        c_eff = (i_req.op == cms_pkg::ALU_SUB) ? 1'b1 : i_req.cin;
        total = {1'b0, i_req.a} + {1'b0, b_eff} + {32'd0, c_eff};
    end

    assign o_rsp.res  = total[31:0];
    assign o_rsp.cout = total[32];

endmodule

@@ hw/rtl/cms_engine.sv @@
// Sequencer and series state; every arithmetic step goes through one shared ALU.
`timescale 1ns / 1ps

module cms_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cms_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cms_pkg::t_in_item    i_in_data,
    input  logic                 i_out_free,
    output logic                 o_done,
    output cms_pkg::t_out_item   o_result
);

    cms_pkg::t_state   r_state, n_state;
    cms_pkg::t_alu_req alu_req;
    cms_pkg::t_alu_rsp alu_rsp;

    logic [31:0] r_start, n_start;
    logic [31:0] r_stop, n_stop;
    logic        r_restart, n_restart;
    logic [31:0] r_dur, n_dur;
    logic [1:0]  r_err, n_err;
    logic        r_jit, n_jit;
    logic        r_carry, n_carry;
    logic [63:0] r_sum, n_sum;
    logic [31:0] r_min, n_min;
    logic [31:0] r_max, n_max;
    logic [31:0] r_avg, n_avg;
    logic [31:0] r_outl, n_outl;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [cms_pkg::StepWidth-1:0] r_step, n_step;

    logic [31:0] cnt_eff;
    logic        cap_err;
    logic        first;
    logic [31:0] trial;
    logic        div_ge;

    cms_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign cnt_eff = r_restart ? 32'd0 : r_cnt;
    assign first   = (cnt_eff == 32'd0);
    assign cap_err = (cnt_eff == '1) || ((i_cfg.capacity != '0) && alu_rsp.cout);
    assign trial   = {r_rem[30:0], r_quo[31]};
    assign div_ge  = r_rem[31] || alu_rsp.cout;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cms_pkg::S_IDLE:   if (i_in_valid) n_state = cms_pkg::S_DIFF;
            cms_pkg::S_DIFF:   n_state = cms_pkg::S_OVH;
            cms_pkg::S_OVH:    n_state = alu_rsp.cout ? cms_pkg::S_CAP : cms_pkg::S_DONE;
            cms_pkg::S_CAP: begin
                if (cap_err) n_state = cms_pkg::S_DONE;
                else if (first) n_state = cms_pkg::S_SUM_LO;
                else n_state = cms_pkg::S_MIN;
            end
            cms_pkg::S_MIN:    n_state = cms_pkg::S_MAX;
            cms_pkg::S_MAX:    n_state = cms_pkg::S_AVG;
            cms_pkg::S_AVG:    n_state = (alu_rsp.res != '0) ? cms_pkg::S_OUT
                                                             : cms_pkg::S_SUM_LO;
            cms_pkg::S_OUT:    n_state = cms_pkg::S_SUM_LO;
            cms_pkg::S_SUM_LO: n_state = cms_pkg::S_SUM_HI;
            cms_pkg::S_SUM_HI: n_state = cms_pkg::S_CNT;
            cms_pkg::S_CNT:    n_state = cms_pkg::S_DIV;
            cms_pkg::S_DIV:    if (r_step == '1) n_state = cms_pkg::S_DONE;
            cms_pkg::S_DONE:   if (i_out_free) n_state = cms_pkg::S_IDLE;
            default:           n_state = cms_pkg::S_IDLE;
        endcase
    end

    // ALU operands and datapath updates.
    always_comb begin
        alu_req.op  = cms_pkg::ALU_SUB;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.cin = 1'b0;

        n_start   = r_start;
        n_stop    = r_stop;
        n_restart = r_restart;
        n_dur     = r_dur;
        n_err     = r_err;
        n_jit     = r_jit;
        n_carry   = r_carry;
        n_sum     = r_sum;
        n_min     = r_min;
        n_max     = r_max;
        n_avg     = r_avg;
        n_outl    = r_outl;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;

        unique case (r_state)
            cms_pkg::S_IDLE: begin
                n_start   = i_in_data.start_time;
                n_stop    = i_in_data.stop_time;
                n_restart = i_in_data.restart;
                n_err     = cms_pkg::ERR_OK;
                n_jit     = 1'b0;
            end
            cms_pkg::S_DIFF: begin
                alu_req.a = r_stop;
                alu_req.b = r_start;
                n_dur     = alu_rsp.res;
            end
            cms_pkg::S_OVH: begin
                // Borrow means the overhead exceeds the raw difference.
                alu_req.a = r_dur;
                alu_req.b = i_cfg.overhead;
                if (alu_rsp.cout) n_dur = alu_rsp.res;
                else n_err = cms_pkg::ERR_OVERHEAD;
            end
            cms_pkg::S_CAP: begin
                alu_req.a = cnt_eff;
                alu_req.b = {15'd0, i_cfg.capacity};
                if (cap_err) begin
                    n_err = cms_pkg::ERR_CAPACITY;
                end else begin
                    if (r_restart) begin
                        n_avg  = '0;
                        n_outl = '0;
                        n_cnt  = '0;
                    end
                    if (first) begin
                        n_min = r_dur;
                        n_max = r_dur;
                        n_sum = '0;
                    end
                end
            end
            cms_pkg::S_MIN: begin
                alu_req.a = r_dur;
                alu_req.b = r_min;
                if (!alu_rsp.cout) n_min = r_dur;
            end
            cms_pkg::S_MAX: begin
                alu_req.a = r_max;
                alu_req.b = r_dur;
                if (!alu_rsp.cout) n_max = r_dur;
            end
            cms_pkg::S_AVG: begin
                alu_req.a = r_dur;
                alu_req.b = r_avg;
                n_jit     = (alu_rsp.res != '0);
            end
            cms_pkg::S_OUT: begin
                alu_req.op  = cms_pkg::ALU_ADD;
                alu_req.a   = r_outl;
                alu_req.cin = 1'b1;
                n_outl      = alu_rsp.res;
            end
            cms_pkg::S_SUM_LO: begin
                alu_req.op  = cms_pkg::ALU_ADD;
                alu_req.a   = r_sum[31:0];
                alu_req.b   = r_dur;
                n_sum[31:0] = alu_rsp.res;
                n_carry     = alu_rsp.cout;
            end
            cms_pkg::S_SUM_HI: begin
                alu_req.op   = cms_pkg::ALU_ADD;
                alu_req.a    = r_sum[63:32];
                alu_req.cin  = r_carry;
                n_sum[63:32] = alu_rsp.res;
            end
            cms_pkg::S_CNT: begin
                alu_req.op  = cms_pkg::ALU_ADD;
                alu_req.a   = r_cnt;
                alu_req.cin = 1'b1;
                n_cnt       = alu_rsp.res;
                // The high word of the sum is below the count, so the
                // quotient fits in 32 bits.
                n_rem       = r_sum[63:32];
                n_quo       = r_sum[31:0];
                n_step      = '0;
            end
            cms_pkg::S_DIV: begin
                alu_req.a = trial;
                alu_req.b = r_cnt;
                n_rem     = div_ge ? alu_rsp.res : trial;
                n_quo     = {r_quo[30:0], div_ge};
                n_step    = r_step + 1'b1;
                if (r_step == '1) n_avg = {r_quo[30:0], div_ge};
            end
            cms_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cms_pkg::S_IDLE;
            r_step  <= '0;
            r_err   <= cms_pkg::ERR_OK;
            r_jit   <= 1'b0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_avg   <= '0;
            r_outl  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_err   <= n_err;
            r_jit   <= n_jit;
            r_sum   <= n_sum;
            r_min   <= n_min;
            r_max   <= n_max;
            r_avg   <= n_avg;
            r_outl  <= n_outl;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_stop    <= n_stop;
        r_restart <= n_restart;
        r_dur     <= n_dur;
        r_carry   <= n_carry;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
    end

    assign o_in_ready = (r_state == cms_pkg::S_IDLE);
    assign o_done     = (r_state == cms_pkg::S_DONE);

    always_comb begin
        o_result.duration      = (r_err == cms_pkg::ERR_OK) ? r_dur : 32'd0;
        o_result.minimum       = r_min;
        o_result.maximum       = r_max;
        o_result.average       = r_avg;
        o_result.outlier_count = r_outl;
        o_result.sample_count  = r_cnt;
        o_result.jitter        = r_jit;
        o_result.error_code    = r_err;
    end

endmodule

@@ hw/rtl/cycle_measurement_statistics_core.sv @@
// Top level of the cycle measurement statistics core.
`timescale 1ns / 1ps

// Each input transaction carries a start and a stop reading of a free-running
// 32-bit cycle counter. The core takes their wrapping difference, subtracts the
// static overhead register and folds the corrected duration into the series
// statistics: minimum, maximum, 64-bit running sum, sample count, floor average
// and outlier count (a sample that differs from the average held before it).
// A sample rejected because the overhead exceeds the difference or because the
// series capacity is reached leaves all statistics untouched and reports its
// error code with the current state. One sequencer drives a single shared
// 32-bit adder/subtractor for every step, including a restoring division of
// the sum by the count at one quotient bit per cycle. The first sample of a
// series skips the compare steps, and a rejected sample skips all later steps;
// the next transaction is accepted only once the engine is back in idle. The
// 32 division steps dominate. The result is held in an output register, so the
// engine finishes the next sample while the previous result still waits; it
// stalls only when a new result is ready and the old one has not been taken.
// Configuration registers are written over APB at byte address 0 (static
// overhead) and 4 (series capacity, zero means no limit). The user must write
// them only while the core is idle; the block itself does not enforce this.

module cycle_measurement_statistics_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cms_pkg::AddrWidth-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  cms_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output cms_pkg::t_out_item                 o_out_data
);

    cms_pkg::t_cfg      cfg;
    cms_pkg::t_out_item eng_result;
    logic               eng_done;
    logic               out_free;

    logic               r_out_valid, n_out_valid;
    cms_pkg::t_out_item r_out_data, n_out_data;

    cms_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cms_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_done     (eng_done),
        .o_result   (eng_result)
    );

    // The output register can take a new result when it is empty or when its
    // current transaction completes in this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (eng_done && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = eng_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hw/rtl/cms_checker.sv @@
// Port-level checker for the cycle measurement statistics core, with its bind.
`timescale 1ns / 1ps

module cms_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [cms_pkg::AddrWidth-1:0]      paddr,
    input logic [31:0]                        pwdata,
    input logic [31:0]                        prdata,
    input logic                               pready,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input cms_pkg::t_in_item                  i_in_data,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input cms_pkg::t_out_item                 o_out_data
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Accepting a transaction makes the core busy, so it never accepts back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // A rejected sample reports no duration and no jitter.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_code != cms_pkg::ERR_OK)
        |-> (o_out_data.duration == 32'd0) && !o_out_data.jitter)
        else $error("rejected sample carries duration or jitter");

    // An accepted sample lies within the series bounds, as does the average.
    a_ok_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_code == cms_pkg::ERR_OK)
        |-> (o_out_data.sample_count != 32'd0)
            && (o_out_data.minimum <= o_out_data.duration)
            && (o_out_data.duration <= o_out_data.maximum)
            && (o_out_data.minimum <= o_out_data.average)
            && (o_out_data.average <= o_out_data.maximum))
        else $error("accepted sample outside series statistics");

    // The outlier count never exceeds the number of samples in the series.
    a_outliers_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.outlier_count <= o_out_data.sample_count)
        else $error("outlier count exceeds sample count");

endmodule

bind cycle_measurement_statistics_core cms_checker u_cms_checker (.*);
